// ===== design/tbo_pkg.sv =====
// ----------------------------------------------------------------------------
// tbo_pkg: shared widths and helpers for the triangle/box overlap core
// Coordinate widths derived from one constant.
// ----------------------------------------------------------------------------
package tbo_pkg;
	localparam int COORD_WIDTH = 24;
	localparam int HALF_WIDTH  = COORD_WIDTH - 1;
	localparam int REL_W  = COORD_WIDTH + 1;  // vertex minus centre
	localparam int EDGE_W = COORD_WIDTH + 2;  // difference of relative vertices
	localparam int PROD_W = EDGE_W + REL_W;   // edge times coordinate
	localparam int PROJ_W = PROD_W + 1;       // difference of two products
	localparam int RAD_W  = EDGE_W + HALF_WIDTH + 1;
	localparam int NRM_W  = 2 * EDGE_W + 1;
	localparam int OFS_W  = REL_W + 1;        // +-h minus vertex
	localparam int DOT_W  = NRM_W + OFS_W + 2;
	localparam int NLO_W  = NRM_W / 2;        // low half of the normal, unsigned
	localparam int PP_W   = NRM_W - NLO_W + 1 + OFS_W;  // half-normal times offset

	localparam logic [1:0] REG_HX = 2'd0;
	localparam logic [1:0] REG_HY = 2'd1;
	localparam logic [1:0] REG_HZ = 2'd2;

	typedef logic signed [REL_W-1:0]  rel_t;
	typedef logic signed [EDGE_W-1:0] edge_t;
	typedef logic signed [PROJ_W-1:0] proj_t;
	typedef logic signed [RAD_W-1:0]  rad_t;
	typedef logic signed [NRM_W-1:0]  nrm_t;
	typedef logic signed [DOT_W-1:0]  dot_t;
	typedef logic [HALF_WIDTH-1:0]    half_t;

	// strict outside test: all three projections above rad, or all below -rad
	function automatic logic sep3(input proj_t p0, input proj_t p1, input proj_t p2,
			input rad_t rad);
		logic signed [PROJ_W:0] r;
		logic signed [PROJ_W:0] a, b, c;
		logic lo_out, hi_out;
		r = (PROJ_W+1)'(rad);
		a = (PROJ_W+1)'(p0); b = (PROJ_W+1)'(p1); c = (PROJ_W+1)'(p2);
		lo_out = (a > r) && (b > r) && (c > r);
		hi_out = (a < -r) && (b < -r) && (c < -r);
		return lo_out || hi_out;
	endfunction
endpackage

// ===== design/triangle_box_overlap_test_core.sv =====
// ----------------------------------------------------------------------------
// triangle_box_overlap_test_core: separating-axis triangle versus box test
// Six-stage pipeline, one test per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage: present a triangle and box centre with in_valid; a beat is taken
// when in_valid is high and in_stall low. One beat carrying overlaps comes
// out per input beat, out_valid/out_stall handshake.
// Stages: s1 relative vertices and face tests; s2 edges and edge products;
// s3 projections, radii and normal products; s4 normal and plane offsets;
// s5 plane partial products on the two halves of the normal;
// s6 plane dot products and final combine (held in the output register).
// Throughput is one beat per cycle while out_stall is low; no stage is more than one multiply deep.
// Stalls: the whole pipe freezes when the output beat is stalled, except that
// bubbles collapse, so in_stall is raised only when all stages hold beats
// and the output is stalled. Nothing is lost or repeated.
// Reset clears all valid bits; half extents return to 0.5 (128).
// The user writes half extents over APB at 0, 4, 8 only while the core is idle; the core does not enforce it.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test_core (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [tbo_pkg::COORD_WIDTH-1:0] vertex_a_x,
	input  logic signed [tbo_pkg::COORD_WIDTH-1:0] vertex_a_y,
	input  logic signed [tbo_pkg::COORD_WIDTH-1:0] vertex_a_z,
	input  logic signed [tbo_pkg::COORD_WIDTH-1:0] vertex_b_x,
	input  logic signed [tbo_pkg::COORD_WIDTH-1:0] vertex_b_y,
	input  logic signed [tbo_pkg::COORD_WIDTH-1:0] vertex_b_z,
	input  logic signed [tbo_pkg::COORD_WIDTH-1:0] vertex_c_x,
	input  logic signed [tbo_pkg::COORD_WIDTH-1:0] vertex_c_y,
	input  logic signed [tbo_pkg::COORD_WIDTH-1:0] vertex_c_z,
	input  logic signed [tbo_pkg::COORD_WIDTH-1:0] center_x,
	input  logic signed [tbo_pkg::COORD_WIDTH-1:0] center_y,
	input  logic signed [tbo_pkg::COORD_WIDTH-1:0] center_z,
	output logic out_valid,
	input  logic out_stall,
	output logic overlaps
);
	import tbo_pkg::*;

	half_t hx, hy, hz;
	tbo_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.hx(hx), .hy(hy), .hz(hz)
	);

	logic signed [HALF_WIDTH:0] hs [3];
	assign hs[0] = {1'b0, hx};
	assign hs[1] = {1'b0, hy};
	assign hs[2] = {1'b0, hz};

	logic v1, v2, v3, v4, v5, v6;
	logic en1, en2, en3, en4, en5, en6;
	assign en6 = !v6 || !out_stall;
	assign en5 = !v5 || en6;
	assign en4 = !v4 || en5;
	assign en3 = !v3 || en4;
	assign en2 = !v2 || en3;
	assign en1 = !v1 || en2;
	assign in_stall = !en1;

	// ---- stage 1: relative vertices, face axes
	rel_t v_s1 [3][3];
	logic rej_s1;
	logic signed [COORD_WIDTH-1:0] vin [3][3];
	logic signed [COORD_WIDTH-1:0] cin [3];
	assign vin[0][0] = vertex_a_x; assign vin[0][1] = vertex_a_y; assign vin[0][2] = vertex_a_z;
	assign vin[1][0] = vertex_b_x; assign vin[1][1] = vertex_b_y; assign vin[1][2] = vertex_b_z;
	assign vin[2][0] = vertex_c_x; assign vin[2][1] = vertex_c_y; assign vin[2][2] = vertex_c_z;
	assign cin[0] = center_x; assign cin[1] = center_y; assign cin[2] = center_z;

	rel_t vr [3][3];
	logic face_rej;
	always_comb begin
		face_rej = 1'b0;
		for (int k = 0; k < 3; k++)
			for (int d = 0; d < 3; d++)
				vr[k][d] = REL_W'(vin[k][d]) - REL_W'(cin[d]);
		for (int d = 0; d < 3; d++)
			face_rej = face_rej || sep3(PROJ_W'(vr[0][d]), PROJ_W'(vr[1][d]),
				PROJ_W'(vr[2][d]), RAD_W'(hs[d]));
	end
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			v_s1 <= vr;
			rej_s1 <= face_rej;
		end
	end

	// ---- stage 2: edges and edge-coordinate products
	localparam int PI [3] = '{1, 0, 0};
	localparam int PJ [3] = '{2, 2, 1};
	rel_t v_s2 [3][3];
	edge_t e_s2 [3][3];
	logic signed [PROD_W-1:0] pj_s2 [3][3][3], pi_s2 [3][3][3];
	logic rej_s2;
	edge_t ec [3][3];
	always_comb begin
		for (int d = 0; d < 3; d++) begin
			ec[0][d] = EDGE_W'(v_s1[1][d]) - EDGE_W'(v_s1[0][d]);
			ec[1][d] = EDGE_W'(v_s1[2][d]) - EDGE_W'(v_s1[1][d]);
			ec[2][d] = EDGE_W'(v_s1[0][d]) - EDGE_W'(v_s1[2][d]);
		end
	end
	always_ff @(posedge clk) begin
		if (en2 && v1) begin
			v_s2 <= v_s1;
			e_s2 <= ec;
			rej_s2 <= rej_s1;
			for (int t = 0; t < 3; t++)
				for (int q = 0; q < 3; q++)
					for (int k = 0; k < 3; k++) begin
						pj_s2[t][q][k] <= PROD_W'(ec[t][PJ[q]]) * PROD_W'(v_s1[k][PI[q]]);
						pi_s2[t][q][k] <= PROD_W'(ec[t][PI[q]]) * PROD_W'(v_s1[k][PJ[q]]);
					end
		end
	end

	// ---- stage 3: edge-axis tests, normal products
	rel_t v0_s3 [3];
	logic rej_s3;
	logic signed [NRM_W-1:0] np_s3 [6];
	edge_t ae [3][3];
	logic edge_rej;
	always_comb begin
		edge_rej = 1'b0;
		for (int t = 0; t < 3; t++)
			for (int d = 0; d < 3; d++)
				ae[t][d] = e_s2[t][d][EDGE_W-1] ? -e_s2[t][d] : e_s2[t][d];
		for (int t = 0; t < 3; t++)
			for (int q = 0; q < 3; q++)
				edge_rej = edge_rej || sep3(
					PROJ_W'(pj_s2[t][q][0]) - PROJ_W'(pi_s2[t][q][0]),
					PROJ_W'(pj_s2[t][q][1]) - PROJ_W'(pi_s2[t][q][1]),
					PROJ_W'(pj_s2[t][q][2]) - PROJ_W'(pi_s2[t][q][2]),
					RAD_W'(ae[t][PJ[q]]) * RAD_W'(hs[PI[q]])
					+ RAD_W'(ae[t][PI[q]]) * RAD_W'(hs[PJ[q]]));
	end
	always_ff @(posedge clk) begin
		if (en3 && v2) begin
			for (int d = 0; d < 3; d++) v0_s3[d] <= v_s2[0][d];
			rej_s3 <= rej_s2 || edge_rej;
			np_s3[0] <= NRM_W'(e_s2[0][1]) * NRM_W'(e_s2[1][2]);
			np_s3[1] <= NRM_W'(e_s2[0][2]) * NRM_W'(e_s2[1][1]);
			np_s3[2] <= NRM_W'(e_s2[0][2]) * NRM_W'(e_s2[1][0]);
			np_s3[3] <= NRM_W'(e_s2[0][0]) * NRM_W'(e_s2[1][2]);
			np_s3[4] <= NRM_W'(e_s2[0][0]) * NRM_W'(e_s2[1][1]);
			np_s3[5] <= NRM_W'(e_s2[0][1]) * NRM_W'(e_s2[1][0]);
		end
	end

	// ---- stage 4: normal and box corner offsets
	nrm_t n_s4 [3];
	logic signed [OFS_W-1:0] omin_s4 [3], omax_s4 [3];
	logic rej_s4;
	nrm_t nc [3];
	always_comb begin
		nc[0] = np_s3[0] - np_s3[1];
		nc[1] = np_s3[2] - np_s3[3];
		nc[2] = np_s3[4] - np_s3[5];
	end
	always_ff @(posedge clk) begin
		if (en4 && v3) begin
			rej_s4 <= rej_s3;
			for (int d = 0; d < 3; d++) begin
				n_s4[d] <= nc[d];
				if (!nc[d][NRM_W-1] && nc[d] != '0) begin
					omin_s4[d] <= -OFS_W'(hs[d]) - OFS_W'(v0_s3[d]);
					omax_s4[d] <= OFS_W'(hs[d]) - OFS_W'(v0_s3[d]);
				end else begin
					omin_s4[d] <= OFS_W'(hs[d]) - OFS_W'(v0_s3[d]);
					omax_s4[d] <= -OFS_W'(hs[d]) - OFS_W'(v0_s3[d]);
				end
			end
		end
	end

	// ---- stage 5: normal split into an unsigned low half and a signed high half
	logic signed [PP_W-1:0] plo_min_s5 [3], phi_min_s5 [3];
	logic signed [PP_W-1:0] plo_max_s5 [3], phi_max_s5 [3];
	logic rej_s5;
	always_ff @(posedge clk) begin
		if (en5 && v4) begin
			rej_s5 <= rej_s4;
			for (int d = 0; d < 3; d++) begin
				plo_min_s5[d] <= PP_W'($signed({1'b0, n_s4[d][NLO_W-1:0]}))
					* PP_W'(omin_s4[d]);
				phi_min_s5[d] <= PP_W'($signed(n_s4[d][NRM_W-1:NLO_W]))
					* PP_W'(omin_s4[d]);
				plo_max_s5[d] <= PP_W'($signed({1'b0, n_s4[d][NLO_W-1:0]}))
					* PP_W'(omax_s4[d]);
				phi_max_s5[d] <= PP_W'($signed(n_s4[d][NRM_W-1:NLO_W]))
					* PP_W'(omax_s4[d]);
			end
		end
	end

	// ---- stage 6: plane dot products and final decision
	dot_t dmin, dmax;
	always_comb begin
		dmin = '0;
		dmax = '0;
		for (int d = 0; d < 3; d++) begin
			dmin = dmin + (DOT_W'(phi_min_s5[d]) <<< NLO_W) + DOT_W'(plo_min_s5[d]);
			dmax = dmax + (DOT_W'(phi_max_s5[d]) <<< NLO_W) + DOT_W'(plo_max_s5[d]);
		end
	end
	logic ov_s6;
	always_ff @(posedge clk) begin
		if (en6 && v5)
			ov_s6 <= !rej_s5 && !(!dmin[DOT_W-1] && dmin != '0) && !dmax[DOT_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
		end else begin
			if (en1) v1 <= in_valid;
			if (en2) v2 <= v1;
			if (en3) v3 <= v2;
			if (en4) v4 <= v3;
			if (en5) v5 <= v4;
			if (en6) v6 <= v5;
		end
	end
	assign out_valid = v6;
	assign overlaps = ov_s6;
endmodule

// ===== design/tbo_cfg.sv =====
// ----------------------------------------------------------------------------
// tbo_cfg: APB register file for the half extents
// Three writable, readable registers at byte addresses 0, 4, 8.
// ----------------------------------------------------------------------------
module tbo_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output tbo_pkg::half_t hx,
	output tbo_pkg::half_t hy,
	output tbo_pkg::half_t hz
);
	import tbo_pkg::*;
	half_t hx_q, hy_q, hz_q;
	logic wr;
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hx_q <= HALF_WIDTH'(128);
			hy_q <= HALF_WIDTH'(128);
			hz_q <= HALF_WIDTH'(128);
		end else if (wr) begin
			case (paddr[3:2])
				REG_HX: hx_q <= pwdata[HALF_WIDTH-1:0];
				REG_HY: hy_q <= pwdata[HALF_WIDTH-1:0];
				REG_HZ: hz_q <= pwdata[HALF_WIDTH-1:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[3:2])
			REG_HX: prdata = 32'(hx_q);
			REG_HY: prdata = 32'(hy_q);
			REG_HZ: prdata = 32'(hz_q);
			default: prdata = '0;
		endcase
	end
	assign hx = hx_q;
	assign hy = hy_q;
	assign hz = hz_q;
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: triangle/box overlap core testbench
// Drives triangles and box centres through the valid/stall port, programmes
// the half extents over APB between phases, and checks every overlap beat
// against a full-width separating-axis predictor.
// ----------------------------------------------------------------------------
module tb;
	import tbo_pkg::*;

	localparam int CW = COORD_WIDTH;
	typedef logic signed [127:0] wide_t;
	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		coord_t v[9];
		coord_t c[3];
	} tri_box_t;

	class overlap_board;
		bit exp_q[$];
		half_t hext[3];
		int errors;

		function new();
			hext[0] = 128; hext[1] = 128; hext[2] = 128;
			errors = 0;
		endfunction

		// true when all three projections lie strictly above rad or all strictly below -rad
		function automatic bit apart(wide_t p0, wide_t p1, wide_t p2, wide_t rad);
			wide_t lo, hi;
			lo = p0; hi = p0;
			if (p1 < lo) lo = p1;
			if (p2 < lo) lo = p2;
			if (p1 > hi) hi = p1;
			if (p2 > hi) hi = p2;
			return (lo > rad) || (hi < -rad);
		endfunction

		function automatic bit overlap_of(tri_box_t t);
			wide_t v[3][3], e[3][3], h[3], n[3], p[3], rad, dmin, dmax, cmin, cmax;
			int ai[3], aj[3], i, j;
			ai = '{1, 0, 0};
			aj = '{2, 2, 1};
			for (int d = 0; d < 3; d++) begin
				h[d] = wide_t'({1'b0, hext[d]});
				for (int k = 0; k < 3; k++)
					v[k][d] = wide_t'(t.v[3*k+d]) - wide_t'(t.c[d]);
			end
			for (int d = 0; d < 3; d++) begin
				e[0][d] = v[1][d] - v[0][d];
				e[1][d] = v[2][d] - v[1][d];
				e[2][d] = v[0][d] - v[2][d];
			end
			for (int s = 0; s < 3; s++)
				for (int q = 0; q < 3; q++) begin
					i = ai[q]; j = aj[q];
					rad = (e[s][j] < 0 ? -e[s][j] : e[s][j]) * h[i]
						+ (e[s][i] < 0 ? -e[s][i] : e[s][i]) * h[j];
					for (int k = 0; k < 3; k++)
						p[k] = e[s][j] * v[k][i] - e[s][i] * v[k][j];
					if (apart(p[0], p[1], p[2], rad)) return 0;
				end
			for (int d = 0; d < 3; d++)
				if (apart(v[0][d], v[1][d], v[2][d], h[d])) return 0;
			n[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
			n[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
			n[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
			dmin = 0; dmax = 0;
			for (int d = 0; d < 3; d++) begin
				cmin = n[d] > 0 ? -h[d] : h[d];
				cmax = n[d] > 0 ? h[d] : -h[d];
				dmin += n[d] * (cmin - v[0][d]);
				dmax += n[d] * (cmax - v[0][d]);
			end
			if (dmin > 0) return 0;
			return dmax >= 0;
		endfunction

		function void note_input(tri_box_t t);
			exp_q.push_back(overlap_of(t));
		endfunction

		function void check_result(bit got);
			bit want;
			if (exp_q.size() == 0) begin
				$error("overlaps: unexpected beat, actual %0d", got);
				errors++;
				return;
			end
			want = exp_q.pop_front();
			if (want !== got) begin
				$error("overlaps: expected %0d actual %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_stall, out_valid, out_stall, overlaps;
	coord_t vin[9];
	coord_t cin[3];

	overlap_board board = new();
	tri_box_t stim_q[$];
	int stall_free;

	triangle_box_overlap_test_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.vertex_a_x(vin[0]), .vertex_a_y(vin[1]), .vertex_a_z(vin[2]),
		.vertex_b_x(vin[3]), .vertex_b_y(vin[4]), .vertex_b_z(vin[5]),
		.vertex_c_x(vin[6]), .vertex_c_y(vin[7]), .vertex_c_z(vin[8]),
		.center_x(cin[0]), .center_y(cin[1]), .center_z(cin[2]),
		.out_valid(out_valid), .out_stall(out_stall), .overlaps(overlaps)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	// output side: random stall, quiet stretch while stall_free is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) board.check_result(overlaps);
			out_stall <= (stall_free == 0) && ($urandom_range(99) < 6);
		end
	end

	task automatic apb_write(logic [1:0] idx, half_t val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		board.hext[idx] = val;
	endtask

	task automatic set_box(half_t hx, half_t hy, half_t hz);
		while (board.exp_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		apb_write(REG_HX, hx);
		apb_write(REG_HY, hy);
		apb_write(REG_HZ, hz);
	endtask

	// called at a rising edge; beats follow back to back unless idling
	task automatic send_all(bit quiet);
		tri_box_t t;
		while (stim_q.size() != 0) begin
			t = stim_q.pop_front();
			while (!quiet && $urandom_range(99) < 6) begin
				in_valid <= 0;
				@(posedge clk);
			end
			in_valid <= 1;
			vin <= t.v; cin <= t.c;
			do @(posedge clk); while (in_stall);
			board.note_input(t);
		end
		in_valid <= 0;
	endtask

	function automatic coord_t rnd_small(int span);
		return coord_t'($signed($urandom_range(2*span)) - span);
	endfunction

	function automatic coord_t rnd_full();
		return coord_t'($urandom);
	endfunction

	task automatic queue_item(coord_t v[9], coord_t c[3]);
		tri_box_t t;
		t.v = v; t.c = c;
		stim_q.push_back(t);
	endtask

	// mostly triangles near the box so every test gets exercised
	task automatic queue_random(int count, int span);
		coord_t v[9], c[3];
		int mode;
		repeat (count) begin
			mode = $urandom_range(9);
			for (int d = 0; d < 3; d++) c[d] = (mode == 0) ? rnd_full() : rnd_small(2000);
			for (int k = 0; k < 9; k++)
				v[k] = (mode == 0) ? rnd_full() : coord_t'(c[k%3] + rnd_small(span));
			if (mode == 1) for (int d = 0; d < 3; d++) v[6+d] = v[d];  // degenerate
			if (mode == 2) for (int d = 0; d < 3; d++) v[3+d] = v[d];
			queue_item(v, c);
		end
	endtask

	initial begin
		coord_t v[9], c[3];
		coord_t mx, mn;
		mx = {1'b0, {(CW-1){1'b1}}};
		mn = {1'b1, {(CW-1){1'b0}}};
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; stall_free = 0;
		foreach (vin[k]) vin[k] = 0;
		foreach (cin[k]) cin[k] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, touching, degenerate, far apart
		foreach (v[k]) v[k] = mx;
		foreach (c[k]) c[k] = mn;
		queue_item(v, c);
		foreach (v[k]) v[k] = mn;
		foreach (c[k]) c[k] = mx;
		queue_item(v, c);
		v = '{mx, mn, mx, mn, mx, mn, 0, 0, 0}; c = '{mn, mx, 0};
		queue_item(v, c);
		v = '{128, 0, 0, 0, 128, 0, 0, 0, 128}; c = '{0, 0, 0};  // touching corners
		queue_item(v, c);
		v = '{129, 0, 0, 129, 128, 0, 129, 0, 128}; c = '{0, 0, 0};
		queue_item(v, c);
		v = '{384, 0, 0, 0, 384, 0, 0, 0, 384}; c = '{0, 0, 0};  // plane grazes corner
		queue_item(v, c);
		v = '{385, 0, 0, 0, 385, 0, 0, 0, 385}; c = '{0, 0, 0};
		queue_item(v, c);
		v = '{-500, 0, 0, 500, 0, 0, 500, 0, 0}; c = '{0, 0, 0};  // degenerate segment
		queue_item(v, c);
		v = '{-500, 200, 0, 500, 200, 0, 0, 200, 0}; c = '{0, 0, 0};
		queue_item(v, c);
		v = '{-1000, -1000, 5, 1000, -1000, 5, 0, 1000, 5}; c = '{0, 0, 0};
		queue_item(v, c);
		v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; c = '{0, 0, 0};
		queue_item(v, c);
		send_all(0);

		set_box(0, 0, 0);  // point box
		v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; c = '{0, 0, 0};
		queue_item(v, c);
		v = '{-300, -300, 0, 300, -300, 0, 0, 300, 0}; c = '{0, 0, 0};
		queue_item(v, c);
		v = '{-300, -300, 1, 300, -300, 1, 0, 300, 1}; c = '{0, 0, 0};
		queue_item(v, c);
		queue_random(60, 600);
		send_all(0);

		set_box(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
		v = '{mx, mx, mx, mn, mn, mn, mx, mn, 0}; c = '{mn, mx, mn};
		queue_item(v, c);
		queue_random(60, 8000000);
		send_all(0);

		set_box(300, 0, 1000);
		queue_random(100, 1500);
		stall_free = 1;
		send_all(1);
		stall_free = 0;

		for (int ph = 0; ph < 3; ph++) begin
			set_box(half_t'($urandom_range(2000)), half_t'($urandom_range(2000)),
				half_t'(ph == 2 ? $urandom : $urandom_range(2000)));
			queue_random(75, 2500);
			send_all(0);
		end

		while (board.exp_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== files.f =====
design/tbo_pkg.sv
design/tbo_cfg.sv
design/triangle_box_overlap_test_core.sv
verif/tb.sv
